// ----- rtl/sfcc_pkg.sv -----
package sfcc_pkg;

   // CRC-8 as used on the frame: polynomial x^8 + x^5 + x^4 + 1, preset to all ones.
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // Bus outcome codes carried with each request.
   localparam logic [1:0] BUS_OK         = 2'd0;
   localparam logic [1:0] BUS_WRITE_FAIL = 2'd1;

   // Result status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_WRITE_ERR = 3'd1;
   localparam logic [2:0] STATUS_READ_ERR  = 3'd2;
   localparam logic [2:0] STATUS_TEMP_CRC  = 3'd3;
   localparam logic [2:0] STATUS_HUM_CRC   = 3'd4;

   // Byte positions within the six-byte frame.
   localparam logic [2:0] POS_TEMP_HI  = 3'd0;
   localparam logic [2:0] POS_TEMP_LO  = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_HI   = 3'd3;
   localparam logic [2:0] POS_HUM_LO   = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [1:0] bus_fail;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] temperature_raw;
      logic [15:0] humidity_raw;
   } rsp_item_type;

   // One byte through the CRC, most significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((r & CRC_TOP) != 8'h00) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ----- rtl/sfcc_if.sv -----
interface sfcc_req_if import sfcc_pkg::*;;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [1:0] bus_fail;

   modport source (output valid, output rx_byte, output bus_fail, input ready);
   modport sink   (input valid, input rx_byte, input bus_fail, output ready);
endinterface

interface sfcc_rsp_if import sfcc_pkg::*;;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] temperature_raw;
   logic [15:0] humidity_raw;

   modport source (output valid, output status, output temperature_raw,
                   output humidity_raw, input ready);
   modport sink   (input valid, input status, input temperature_raw,
                   input humidity_raw, output ready);
endinterface

// ----- rtl/sfcc_in_stage.sv -----
module sfcc_in_stage import sfcc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sfcc_req_if.sink     req_ch,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   // The stage may take a new request when empty or when its item leaves now.
   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{rx_byte: req_ch.rx_byte, bus_fail: req_ch.bus_fail};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // A held item that is not consumed stays in the stage.
   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !advance) |=> valid_ff)
      else $error("input stage lost an item");

   // The stage never consumes an item it does not hold.
   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |-> valid_ff)
      else $error("input stage advanced while empty");

   // A stalled item keeps its payload.
   a_item_stable: assert property (@(posedge clock) disable iff (reset)
      (!reset && valid_ff && !advance) |=> $stable(item_ff))
      else $error("input stage payload changed while stalled");

endmodule

// ----- rtl/sfcc_frame.sv -----
module sfcc_frame import sfcc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_item_type item,
   input  logic         fire,
   output logic         has_result,
   output rsp_item_type result
);

   logic [2:0]  pos_ff,        pos_in;
   logic [7:0]  crc_ff,        crc_in;
   logic [15:0] temp_stage_ff, temp_stage_in;
   logic [15:0] hum_stage_ff,  hum_stage_in;
   logic        temp_fail_ff,  temp_fail_in;
   logic [15:0] temp_held_ff,  temp_held_in;
   logic [15:0] hum_held_ff,   hum_held_in;
   logic [2:0]  pos;
   logic [2:0]  status;
   logic [7:0]  crc_from_init;
   logic [7:0]  crc_from_run;

   assign crc_from_init = crc8_byte(CRC_INIT, item.rx_byte);
   assign crc_from_run  = crc8_byte(crc_ff, item.rx_byte);

   always_comb begin
      pos           = (pos_ff > POS_HUM_CRC) ? POS_TEMP_HI : pos_ff;
      pos_in        = pos + 3'd1;
      crc_in        = crc_ff;
      temp_stage_in = temp_stage_ff;
      hum_stage_in  = hum_stage_ff;
      temp_fail_in  = temp_fail_ff;
      temp_held_in  = temp_held_ff;
      hum_held_in   = hum_held_ff;
      has_result    = 1'b0;
      status        = STATUS_OK;
      if (item.bus_fail != BUS_OK) begin
         has_result   = 1'b1;
         status       = (item.bus_fail == BUS_WRITE_FAIL) ? STATUS_WRITE_ERR : STATUS_READ_ERR;
         pos_in       = POS_TEMP_HI;
         crc_in       = CRC_INIT;
         temp_fail_in = 1'b0;
      end else begin
         case (pos)
            POS_TEMP_HI: begin
               temp_stage_in = {item.rx_byte, 8'h00};
               crc_in        = crc_from_init;
            end
            POS_TEMP_LO: begin
               temp_stage_in = {temp_stage_ff[15:8], item.rx_byte};
               crc_in        = crc_from_run;
            end
            POS_TEMP_CRC: begin
               temp_fail_in = (crc_ff != item.rx_byte);
               crc_in       = CRC_INIT;
            end
            POS_HUM_HI: begin
               hum_stage_in = {item.rx_byte, 8'h00};
               crc_in       = crc_from_init;
            end
            POS_HUM_LO: begin
               hum_stage_in = {hum_stage_ff[15:8], item.rx_byte};
               crc_in       = crc_from_run;
            end
            default: begin
               has_result = 1'b1;
               if (temp_fail_ff) begin
                  status = STATUS_TEMP_CRC;
               end else if (crc_ff != item.rx_byte) begin
                  status = STATUS_HUM_CRC;
               end else begin
                  status       = STATUS_OK;
                  temp_held_in = temp_stage_ff;
                  hum_held_in  = hum_stage_ff;
               end
               pos_in       = POS_TEMP_HI;
               crc_in       = CRC_INIT;
               temp_fail_in = 1'b0;
            end
         endcase
      end
   end

   // The result reports the held words after any update by this byte.
   assign result = '{status: status, temperature_raw: temp_held_in,
                     humidity_raw: hum_held_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_TEMP_HI;
         crc_ff        <= CRC_INIT;
         temp_stage_ff <= 16'h0000;
         hum_stage_ff  <= 16'h0000;
         temp_fail_ff  <= 1'b0;
         temp_held_ff  <= 16'h0000;
         hum_held_ff   <= 16'h0000;
      end else if (fire) begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_stage_ff <= temp_stage_in;
         hum_stage_ff  <= hum_stage_in;
         temp_fail_ff  <= temp_fail_in;
         temp_held_ff  <= temp_held_in;
         hum_held_ff   <= hum_held_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_HUM_CRC)
      else $error("byte position left the frame");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (!reset && fire && has_result) |=> (pos_ff == POS_TEMP_HI && crc_ff == CRC_INIT))
      else $error("frame not restarted after a result");

   a_held_only_ok: assert property (@(posedge clock) disable iff (reset)
      (!reset && !(fire && has_result && status == STATUS_OK))
      |=> ($stable(temp_held_ff) && $stable(hum_held_ff)))
      else $error("held words changed without a good frame");

endmodule

// ----- rtl/sfcc_out_stage.sv -----
module sfcc_out_stage import sfcc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type payload,
   output logic         can_load,
   sfcc_rsp_if.source   rsp_ch
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= payload;
      end
   end

   assign rsp_ch.valid           = valid_ff;
   assign rsp_ch.status          = item_ff.status;
   assign rsp_ch.temperature_raw = item_ff.temperature_raw;
   assign rsp_ch.humidity_raw    = item_ff.humidity_raw;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("result register overwritten before it was taken");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (item_ff.status <= STATUS_HUM_CRC))
      else $error("result carries an undefined status");

   a_pending_kept: assert property (@(posedge clock) disable iff (reset)
      (!reset && valid_ff && !rsp_ch.ready) |=> valid_ff)
      else $error("pending result dropped");

endmodule

// ----- rtl/sensor_frame_crc_checker.sv -----
// Sensor frame checker. Each request carries one received byte of a six-byte
// measurement frame (temperature word high byte first, its CRC, humidity word
// high byte first, its CRC) or a bus failure code. Each word is checked with a
// CRC-8, polynomial 0x31, preset 0xFF, most significant bit first. After the
// sixth byte one result is given: ok, temperature CRC bad (reported even if the
// humidity CRC is also bad) or humidity CRC bad. Both held raw words are
// replaced only when both CRCs match; otherwise the last good words are kept
// and reported. A bus failure drops any partial frame at once and gives a
// result with status write fail (code 1) or read fail (code 2, also used for
// code 3); the next byte opens a new frame. Bytes in the middle of a frame give
// no result. The block takes one request per clock cycle unless a stalled
// response channel holds it back, as told below. A result passes through the
// input register, then the byte-wide CRC update and frame decision, an
// eight-step XOR network, and settles into the state and the result register.
// A stalled response channel holds back the request channel only when a
// request that ends a frame, or reports a failure, is waiting behind it.
module sensor_frame_crc_checker import sfcc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sfcc_req_if.sink     req_ch,
   sfcc_rsp_if.source   rsp_ch
);

   logic         item_valid;
   req_item_type item;
   logic         has_result;
   rsp_item_type result;
   logic         can_load;
   logic         advance;

   // An item leaves the input register when it gives no result, or when the
   // result register is free or being emptied in the same cycle.
   assign advance = item_valid && (!has_result || can_load);

   sfcc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sfcc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .fire       (advance),
      .has_result (has_result),
      .result     (result)
   );

   sfcc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && has_result),
      .payload  (result),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule
